>>> rtl/core/esse_pkg.sv
`default_nettype none
package esse_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned RpmW    = 16;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;
  localparam int unsigned RegIdxW = 3;

  // command codes
  localparam logic [CmdW-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CmdW-1:0] CMD_START  = 2'd1;
  localparam logic [CmdW-1:0] CMD_STOP   = 2'd2;

  // engine status codes
  localparam logic [StatusW-1:0] STATUS_STOPPED  = 2'd0;
  localparam logic [StatusW-1:0] STATUS_STARTING = 2'd1;
  localparam logic [StatusW-1:0] STATUS_RUNNING  = 2'd2;

  // register indexes
  localparam logic [RegIdxW-1:0] REG_RAMP_TOP_RPM = 3'd0;
  localparam logic [RegIdxW-1:0] REG_CRANK_RPM    = 3'd1;
  localparam logic [RegIdxW-1:0] REG_FALL_MS      = 3'd2;
  localparam logic [RegIdxW-1:0] REG_CRANK_MS     = 3'd3;
  localparam logic [RegIdxW-1:0] REG_REST_MS      = 3'd4;
  localparam logic [RegIdxW-1:0] REG_WARMUP_MS    = 3'd5;

  // register reset values
  localparam logic [CfgW-1:0] RST_RAMP_TOP_RPM = 16'd4000;
  localparam logic [CfgW-1:0] RST_CRANK_RPM    = 16'd500;
  localparam logic [CfgW-1:0] RST_FALL_MS      = 16'd1500;
  localparam logic [CfgW-1:0] RST_CRANK_MS     = 16'd1500;
  localparam logic [CfgW-1:0] RST_REST_MS      = 16'd2000;
  localparam logic [CfgW-1:0] RST_WARMUP_MS    = 16'd3000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_RESOLVE,
    ST_FIN
  } state_t;

endpackage
`default_nettype wire

>>> rtl/core/esse_if.sv
`default_nettype none
interface esse_in_if;
  logic                              valid;
  logic                              ready;
  logic [esse_pkg::CmdW-1:0]         command;
  logic [esse_pkg::TimeW-1:0]        time_ms;
  logic [esse_pkg::RpmW-1:0]         measured_rpm;

  modport source (output valid, output command, output time_ms, output measured_rpm,
                  input ready);
  modport sink   (input valid, input command, input time_ms, input measured_rpm,
                  output ready);
endinterface

interface esse_out_if;
  logic                              valid;
  logic                              ready;
  logic [esse_pkg::StatusW-1:0]      engine_status;
  logic [esse_pkg::RpmW-1:0]         rpm_out;

  modport source (output valid, output engine_status, output rpm_out, input ready);
  modport sink   (input valid, input engine_status, input rpm_out, output ready);
endinterface
`default_nettype wire

>>> rtl/core/engine_status_stall_emulator_unit.sv
`default_nettype none
// Engine status emulator. A sample item (command 0) gives one result: in normal mode the
// measured rpm passes through and the status follows stopped, starting and, after warmup_ms,
// running; in stall mode the rpm ramps down from the ramp-top rpm over fall_ms and then cycles
// between cranking (crank rpm, status starting) and rest (rpm 0, status running). Start and
// stop items give no result. A normal-mode sample occupies the block for the accepting step
// and the output load. A stall-mode sample passes through the accepting step, a setup step,
// 32 steps of the shared restoring divider that forms both the ramp quotient and the cycle
// position, a resolve step and the output load; when the restart cycle after the ramp has
// zero length the divider is skipped. A result still waiting in the output register holds
// the block in its last step. Configuration registers sit at byte addresses 0, 4, ... 20 of
// the APB-style port.
module engine_status_stall_emulator_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  esse_in_if.sink                           in_ch,
  esse_out_if.source                        out_ch,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [esse_pkg::AddrW-1:0]   paddr,
  input  wire logic [esse_pkg::DataW-1:0]   pwdata,
  output logic      [esse_pkg::DataW-1:0]   prdata,
  output logic                              pready
);

  localparam int unsigned DivSteps = esse_pkg::TimeW;
  localparam int unsigned CntW     = $clog2(DivSteps);
  localparam int unsigned DvsW     = esse_pkg::CfgW + 1;

  // configuration registers
  logic [esse_pkg::CfgW-1:0] ramp_top_rpm_r, crank_rpm_r, fall_ms_r;
  logic [esse_pkg::CfgW-1:0] crank_ms_r, rest_ms_r, warmup_ms_r;

  // model state
  logic [esse_pkg::StatusW-1:0] status_now_r;
  logic [esse_pkg::TimeW-1:0]   run_start_ms_r;
  logic                         stall_active_r;
  logic [esse_pkg::TimeW-1:0]   stall_start_ms_r;

  // sequencer and shared divider
  esse_pkg::state_t            state_r, state_nxt;
  logic [esse_pkg::TimeW-1:0]  elapsed_r;
  logic                        ramp_r;
  logic [esse_pkg::TimeW-1:0]  quo_r;
  logic [DvsW-1:0]             rem_r;
  logic [DvsW-1:0]             dvs_r;
  logic [CntW-1:0]             cnt_r;

  logic [esse_pkg::StatusW-1:0] res_status_r;
  logic [esse_pkg::RpmW-1:0]    res_rpm_r;

  logic                         out_valid_r;
  logic [esse_pkg::StatusW-1:0] out_status_r;
  logic [esse_pkg::RpmW-1:0]    out_rpm_r;

  logic in_ready_c, out_load_c;
  logic accept;
  logic cfg_write;
  logic [esse_pkg::RegIdxW-1:0] cfg_idx;

  // combinational datapath pieces
  logic                        in_ramp;
  logic [esse_pkg::CfgW-1:0]   ramp_left;
  logic [esse_pkg::TimeW-1:0]  ramp_prod;
  logic [DvsW-1:0]             cycle_len;
  logic [DvsW:0]               trial;
  logic                        trial_ge;
  logic                        last_step;
  logic [esse_pkg::TimeW-1:0]  since_run;

  assign accept    = in_ch.valid & in_ready_c;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cfg_idx   = paddr[esse_pkg::AddrW-1:2];
  assign pready    = 1'b1;

  assign in_ramp   = elapsed_r < {{(esse_pkg::TimeW-esse_pkg::CfgW){1'b0}}, fall_ms_r};
  assign ramp_left = fall_ms_r - elapsed_r[esse_pkg::CfgW-1:0];
  assign ramp_prod = esse_pkg::TimeW'(ramp_top_rpm_r) * esse_pkg::TimeW'(ramp_left);
  assign cycle_len = {1'b0, crank_ms_r} + {1'b0, rest_ms_r};
  assign trial     = {rem_r, quo_r[esse_pkg::TimeW-1]};
  assign trial_ge  = trial >= {1'b0, dvs_r};
  assign last_step = cnt_r == CntW'(DivSteps - 1);
  assign since_run = in_ch.time_ms - run_start_ms_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      esse_pkg::ST_IDLE: begin
        if (accept && in_ch.command == esse_pkg::CMD_SAMPLE) begin
          state_nxt = stall_active_r ? esse_pkg::ST_SETUP : esse_pkg::ST_FIN;
        end
      end
      esse_pkg::ST_SETUP: begin
        if (!in_ramp && cycle_len == '0) begin
          state_nxt = esse_pkg::ST_FIN;
        end else begin
          state_nxt = esse_pkg::ST_DIV;
        end
      end
      esse_pkg::ST_DIV: begin
        if (last_step) begin
          state_nxt = esse_pkg::ST_RESOLVE;
        end
      end
      esse_pkg::ST_RESOLVE: state_nxt = esse_pkg::ST_FIN;
      esse_pkg::ST_FIN: begin
        if (out_load_c) begin
          state_nxt = esse_pkg::ST_IDLE;
        end
      end
      default: state_nxt = esse_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready_c = 1'b0;
    out_load_c = 1'b0;
    unique case (state_r)
      esse_pkg::ST_IDLE: in_ready_c = 1'b1;
      esse_pkg::ST_FIN:  out_load_c = !out_valid_r || out_ch.ready;
      default: begin
        in_ready_c = 1'b0;
        out_load_c = 1'b0;
      end
    endcase
  end

  assign in_ch.ready          = in_ready_c;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.engine_status = out_status_r;
  assign out_ch.rpm_out       = out_rpm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= esse_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_top_rpm_r <= esse_pkg::RST_RAMP_TOP_RPM;
      crank_rpm_r    <= esse_pkg::RST_CRANK_RPM;
      fall_ms_r      <= esse_pkg::RST_FALL_MS;
      crank_ms_r     <= esse_pkg::RST_CRANK_MS;
      rest_ms_r      <= esse_pkg::RST_REST_MS;
      warmup_ms_r    <= esse_pkg::RST_WARMUP_MS;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        esse_pkg::REG_RAMP_TOP_RPM: ramp_top_rpm_r <= pwdata[esse_pkg::CfgW-1:0];
        esse_pkg::REG_CRANK_RPM:    crank_rpm_r    <= pwdata[esse_pkg::CfgW-1:0];
        esse_pkg::REG_FALL_MS:      fall_ms_r      <= pwdata[esse_pkg::CfgW-1:0];
        esse_pkg::REG_CRANK_MS:     crank_ms_r     <= pwdata[esse_pkg::CfgW-1:0];
        esse_pkg::REG_REST_MS:      rest_ms_r      <= pwdata[esse_pkg::CfgW-1:0];
        esse_pkg::REG_WARMUP_MS:    warmup_ms_r    <= pwdata[esse_pkg::CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      esse_pkg::REG_RAMP_TOP_RPM: prdata[esse_pkg::CfgW-1:0] = ramp_top_rpm_r;
      esse_pkg::REG_CRANK_RPM:    prdata[esse_pkg::CfgW-1:0] = crank_rpm_r;
      esse_pkg::REG_FALL_MS:      prdata[esse_pkg::CfgW-1:0] = fall_ms_r;
      esse_pkg::REG_CRANK_MS:     prdata[esse_pkg::CfgW-1:0] = crank_ms_r;
      esse_pkg::REG_REST_MS:      prdata[esse_pkg::CfgW-1:0] = rest_ms_r;
      esse_pkg::REG_WARMUP_MS:    prdata[esse_pkg::CfgW-1:0] = warmup_ms_r;
      default:                    prdata = '0;
    endcase
  end

  // mode state and status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_now_r     <= esse_pkg::STATUS_STOPPED;
      run_start_ms_r   <= '0;
      stall_active_r   <= 1'b0;
      stall_start_ms_r <= '0;
    end else begin
      unique case (state_r)
        esse_pkg::ST_IDLE: begin
          if (accept) begin
            if (in_ch.command == esse_pkg::CMD_START) begin
              stall_active_r   <= 1'b1;
              stall_start_ms_r <= in_ch.time_ms;
            end else if (in_ch.command == esse_pkg::CMD_STOP) begin
              stall_active_r <= 1'b0;
            end else if (in_ch.command == esse_pkg::CMD_SAMPLE && !stall_active_r) begin
              priority if (in_ch.measured_rpm == '0) begin
                status_now_r <= esse_pkg::STATUS_STOPPED;
              end else if (status_now_r == esse_pkg::STATUS_STOPPED) begin
                status_now_r   <= esse_pkg::STATUS_STARTING;
                run_start_ms_r <= in_ch.time_ms;
              end else if (since_run >
                           {{(esse_pkg::TimeW-esse_pkg::CfgW){1'b0}}, warmup_ms_r}) begin
                status_now_r <= esse_pkg::STATUS_RUNNING;
              end else begin
                status_now_r <= status_now_r;
              end
            end
          end
        end
        esse_pkg::ST_SETUP: begin
          if (!in_ramp && cycle_len == '0) begin
            status_now_r <= esse_pkg::STATUS_RUNNING;
          end
        end
        esse_pkg::ST_RESOLVE: begin
          if (!ramp_r && rem_r < {1'b0, crank_ms_r}) begin
            status_now_r <= esse_pkg::STATUS_STARTING;
          end else begin
            status_now_r <= esse_pkg::STATUS_RUNNING;
          end
        end
        default: ;
      endcase
    end
  end

  // result staging: normal mode resolves on accept, stall mode in the sequencer
  always_ff @(posedge clk) begin
    unique case (state_r)
      esse_pkg::ST_IDLE: begin
        elapsed_r <= in_ch.time_ms - stall_start_ms_r;
        res_rpm_r <= in_ch.measured_rpm;
        priority if (in_ch.measured_rpm == '0) begin
          res_status_r <= esse_pkg::STATUS_STOPPED;
        end else if (status_now_r == esse_pkg::STATUS_STOPPED) begin
          res_status_r <= esse_pkg::STATUS_STARTING;
        end else if (since_run >
                     {{(esse_pkg::TimeW-esse_pkg::CfgW){1'b0}}, warmup_ms_r}) begin
          res_status_r <= esse_pkg::STATUS_RUNNING;
        end else begin
          res_status_r <= status_now_r;
        end
      end
      esse_pkg::ST_SETUP: begin
        ramp_r <= in_ramp;
        rem_r  <= '0;
        cnt_r  <= '0;
        if (in_ramp) begin
          quo_r <= ramp_prod;
          dvs_r <= {1'b0, fall_ms_r};
        end else begin
          quo_r <= elapsed_r - {{(esse_pkg::TimeW-esse_pkg::CfgW){1'b0}}, fall_ms_r};
          dvs_r <= cycle_len;
        end
        // cycle of zero length: hold running with rpm 0
        res_status_r <= esse_pkg::STATUS_RUNNING;
        res_rpm_r    <= '0;
      end
      esse_pkg::ST_DIV: begin
        // one restoring step: shift in the next dividend bit, subtract where it fits
        cnt_r <= cnt_r + CntW'(1);
        quo_r <= {quo_r[esse_pkg::TimeW-2:0], trial_ge};
        if (trial_ge) begin
          rem_r <= DvsW'(trial - {1'b0, dvs_r});
        end else begin
          rem_r <= trial[DvsW-1:0];
        end
      end
      esse_pkg::ST_RESOLVE: begin
        priority if (ramp_r) begin
          res_status_r <= esse_pkg::STATUS_RUNNING;
          res_rpm_r    <= quo_r[esse_pkg::RpmW-1:0];
        end else if (rem_r < {1'b0, crank_ms_r}) begin
          res_status_r <= esse_pkg::STATUS_STARTING;
          res_rpm_r    <= crank_rpm_r;
        end else begin
          res_status_r <= esse_pkg::STATUS_RUNNING;
          res_rpm_r    <= '0;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load_c) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load_c) begin
      out_status_r <= res_status_r;
      out_rpm_r    <= res_rpm_r;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/esse_checker.sv
`default_nettype none
module esse_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic [esse_pkg::CmdW-1:0]       in_command,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [esse_pkg::StatusW-1:0]    out_engine_status,
  input wire logic [esse_pkg::RpmW-1:0]       out_rpm_out
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_engine_status) && $stable(out_rpm_out))
    else $error("stalled result changed");

  // a sample keeps the block busy: ready is low in the cycle after it is accepted
  a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == esse_pkg::CMD_SAMPLE |=> !in_ready)
    else $error("ready stayed high after a sample item");

  // commands other than a sample never produce a result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command != esse_pkg::CMD_SAMPLE && !out_valid |=> !out_valid)
    else $error("result without a sample item");

endmodule

bind engine_status_stall_emulator_unit esse_checker u_esse_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_command        (in_ch.command),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_engine_status (out_ch.engine_status),
  .out_rpm_out       (out_ch.rpm_out)
);
`default_nettype wire
